[hw/rtl/atb_pkg.sv]
// Package for the alias table builder: item types, fixed field widths and
// the request type of the shared divider. Used by atb_div and alias_table_builder.
`default_nettype none
package atb_pkg;

  // Sanitized weight, weight sum and divider numerator widths.
  localparam int WGT_W = 31;
  localparam int SUM_W = 37;
  localparam int NUM_W = 38;

  // Widths of the result fields as they appear on the port.
  localparam int IDX_W  = 6;
  localparam int FRAC_W = 25;

  typedef struct packed {
    logic signed [31:0] weight;
    logic               not_finite;
    logic               last_weight;
  } atb_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic [FRAC_W-1:0] pmf_value;
    logic [FRAC_W-1:0] keep_probability;
    logic [IDX_W-1:0]  alias_index;
    logic [SUM_W-1:0]  total_weight;
    logic              uniform_fallback;
    logic              overflow;
    logic              last_entry;
  } atb_out_t;

  // Request to the divider: start pulse, numerator and divisor.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } atb_div_req_t;

endpackage
`default_nettype wire

[hw/rtl/atb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for every store of the alias table builder.
`default_nettype none
module atb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read; reading the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/atb_div.sv]
// Bit-serial restoring divider: floor(num * 2^FRACTION_BITS / den).
// Depends on atb_pkg for the request type and operand widths.
`default_nettype none
module atb_div #(
  parameter int FRACTION_BITS = 24,
  parameter int QW            = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire atb_pkg::atb_div_req_t req,
  output logic                      done,
  output logic [QW-1:0]             quot
);
  localparam int STEPS = atb_pkg::NUM_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [atb_pkg::SUM_W-1:0]   rem_r, rem_nxt;
  logic [atb_pkg::SUM_W-1:0]   den_r, den_nxt;
  logic [atb_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [QW-1:0]               q_r, q_nxt;
  logic [atb_pkg::SUM_W:0]     trial;
  logic [atb_pkg::SUM_W:0]     diff;
  logic                        ge;

  // One quotient bit per cycle; zeros are shifted in after the numerator.
  always_comb begin
    trial    = {rem_r, num_r[atb_pkg::NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
      rem_nxt  = '0;
      den_nxt  = req.den;
      num_nxt  = req.num;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[atb_pkg::SUM_W-1:0] : trial[atb_pkg::SUM_W-1:0];
      num_nxt = {num_r[atb_pkg::NUM_W-2:0], 1'b0};
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Busy and done are reset; the step counter, operands and quotient are not.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    q_r   <= q_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

[hw/rtl/alias_table_builder.sv]
// Top level of the alias table builder: sequencer over the RAM stores.
// Depends on atb_pkg, atb_ram and atb_div.
//
//   Channel | Direction | Handshake           | Payload
//   in      | input     | in_valid/in_ready   | atb_pkg::atb_in_t
//   out     | output    | out_valid/out_ready | atb_pkg::atb_out_t
//
// Loading accepts one item per cycle. After a last item the build runs a scaling
// pass (each weight times n, divided by the total), then pairing steps (check,
// read small, read large, update), then a result pass (pmf by division, emit),
// both passes using the one-bit-per-cycle divider that they share.
// Reset clears only the control state; the stores need no clearing.
// in_ready is low from the last item until the final result is registered.
`default_nettype none
module alias_table_builder #(
  parameter int ENTRIES       = 64,
  parameter int FRACTION_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire atb_pkg::atb_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output atb_pkg::atb_out_t      out_data
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NW = $clog2(ENTRIES + 1);
  localparam int CW = FRACTION_BITS + NW;
  localparam int KW = FRACTION_BITS + 1;
  localparam int PW = atb_pkg::WGT_W + NW;
  localparam logic [CW-1:0] ONE_FX = CW'(1) << FRACTION_BITS;

  typedef enum logic [3:0] {
    S_LOAD, S_PREP, S_SC_RD, S_SC_MUL, S_SC_GO, S_SC_WAIT,
    S_PR_CHK, S_PR_RDS, S_PR_RDL, S_PR_UPD,
    S_OUT_RD, S_OUT_GO, S_OUT_WAIT, S_OUT_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [NW-1:0]              cnt_r, cnt_nxt;
  logic [atb_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic                       drop_r, drop_nxt;
  logic [atb_pkg::SUM_W-1:0]  total_r, total_nxt;
  logic                       uni_r, uni_nxt;
  logic [NW-1:0]              i_r, i_nxt;
  logic [NW-1:0]              ns_r, ns_nxt;
  logic [NW-1:0]              nl_r, nl_nxt;
  logic [atb_pkg::NUM_W-1:0]  prod_r, prod_nxt;
  logic [AW-1:0]              l_r, l_nxt;
  logic [CW-1:0]              sv_r, sv_nxt;
  logic [KW-1:0]              keepv_r, keepv_nxt;
  logic [AW-1:0]              aliasv_r, aliasv_nxt;
  logic [CW-1:0]              pmf_r, pmf_nxt;
  logic                       out_valid_r, out_valid_nxt;
  atb_pkg::atb_out_t          out_data_r, out_data_nxt;

  // Store ports.
  logic                      w_we, sc_we, sm_we, lg_we, kp_we, al_we;
  logic [AW-1:0]             w_wa, sc_wa, sm_wa, lg_wa, kp_wa, al_wa;
  logic [AW-1:0]             w_ra, sc_ra, sm_ra, lg_ra, kp_ra, al_ra;
  logic [atb_pkg::WGT_W-1:0] w_wd, w_rd;
  logic [CW-1:0]             sc_wd, sc_rd;
  logic [AW-1:0]             sm_wd, sm_rd, lg_wd, lg_rd, al_wd, al_rd;
  logic [KW-1:0]             kp_wd, kp_rd;

  atb_pkg::atb_div_req_t     div_req;
  logic                      div_done;
  logic [CW-1:0]             div_quot;

  logic [atb_pkg::WGT_W-1:0]    w_in;
  logic [atb_pkg::WGT_W-1:0]    w_eff;
  logic [PW-1:0]                prod_w;
  logic [CW:0]                  nv_w;
  logic [NW-1:0]                ns_dec, nl_dec, i_inc;
  logic [63:0]                  pmf_wide, keep_wide;

  atb_ram #(.WIDTH(atb_pkg::WGT_W), .DEPTH(ENTRIES)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));
  atb_ram #(.WIDTH(CW), .DEPTH(ENTRIES)) u_scaled (
    .clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd));
  atb_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_small (
    .clk(clk), .we(sm_we), .waddr(sm_wa), .wdata(sm_wd), .raddr(sm_ra), .rdata(sm_rd));
  atb_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_large (
    .clk(clk), .we(lg_we), .waddr(lg_wa), .wdata(lg_wd), .raddr(lg_ra), .rdata(lg_rd));
  atb_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_keep (
    .clk(clk), .we(kp_we), .waddr(kp_wa), .wdata(kp_wd), .raddr(kp_ra), .rdata(kp_rd));
  atb_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_alias (
    .clk(clk), .we(al_we), .waddr(al_wa), .wdata(al_wd), .raddr(al_ra), .rdata(al_rd));

  atb_div #(.FRACTION_BITS(FRACTION_BITS), .QW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quot(div_quot));

  // Sanitized input weight and the weight read back, with the uniform case.
  assign w_in   = (!in_data.not_finite && !in_data.weight[31]) ?
                  in_data.weight[atb_pkg::WGT_W-1:0] : '0;
  assign w_eff  = uni_r ? atb_pkg::WGT_W'(1) : w_rd;
  assign prod_w = PW'(w_eff) * PW'(cnt_r);
  assign nv_w   = {1'b0, sc_rd} + {1'b0, sv_r} - {1'b0, ONE_FX};
  assign ns_dec = ns_r - NW'(1);
  assign nl_dec = nl_r - NW'(1);
  assign i_inc  = i_r + NW'(1);
  assign pmf_wide  = 64'(pmf_r);
  assign keep_wide = 64'(keepv_r);

  // Sequencer: load, scale and sort, pair, then report.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    drop_nxt      = drop_r;
    total_nxt     = total_r;
    uni_nxt       = uni_r;
    i_nxt         = i_r;
    ns_nxt        = ns_r;
    nl_nxt        = nl_r;
    prod_nxt      = prod_r;
    l_nxt         = l_r;
    sv_nxt        = sv_r;
    keepv_nxt     = keepv_r;
    aliasv_nxt    = aliasv_r;
    pmf_nxt       = pmf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    w_we = 1'b0; w_wa = cnt_r[AW-1:0]; w_wd = w_in; w_ra = i_r[AW-1:0];
    sc_we = 1'b0; sc_wa = i_r[AW-1:0]; sc_wd = div_quot; sc_ra = sm_rd;
    sm_we = 1'b0; sm_wa = ns_r[AW-1:0]; sm_wd = i_r[AW-1:0]; sm_ra = ns_dec[AW-1:0];
    lg_we = 1'b0; lg_wa = nl_r[AW-1:0]; lg_wd = i_r[AW-1:0]; lg_ra = nl_dec[AW-1:0];
    kp_we = 1'b0; kp_wa = i_r[AW-1:0]; kp_wd = ONE_FX[KW-1:0]; kp_ra = i_r[AW-1:0];
    al_we = 1'b0; al_wa = i_r[AW-1:0]; al_wd = i_r[AW-1:0]; al_ra = i_r[AW-1:0];
    div_req.start = 1'b0;
    div_req.num   = prod_r;
    div_req.den   = total_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < NW'(ENTRIES)) begin
            w_we    = 1'b1;
            sum_nxt = sum_r + atb_pkg::SUM_W'(w_in);
            cnt_nxt = cnt_r + NW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_weight) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        uni_nxt   = (sum_r == '0);
        total_nxt = (sum_r == '0) ? atb_pkg::SUM_W'(cnt_r) : sum_r;
        i_nxt     = '0;
        ns_nxt    = '0;
        nl_nxt    = '0;
        state_nxt = S_SC_RD;
      end
      S_SC_RD: begin
        state_nxt = S_SC_MUL;
      end
      S_SC_MUL: begin
        prod_nxt  = atb_pkg::NUM_W'(prod_w);
        state_nxt = S_SC_GO;
      end
      S_SC_GO: begin
        div_req.start = 1'b1;
        state_nxt     = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        // Store the scaled value, sort the column, preset it as a leftover.
        if (div_done) begin
          sc_we = 1'b1;
          kp_we = 1'b1;
          al_we = 1'b1;
          if (div_quot < ONE_FX) begin
            sm_we  = 1'b1;
            ns_nxt = ns_r + NW'(1);
          end else begin
            lg_we  = 1'b1;
            nl_nxt = nl_r + NW'(1);
          end
          i_nxt     = i_inc;
          state_nxt = (i_inc == cnt_r) ? S_PR_CHK : S_SC_RD;
        end
      end
      S_PR_CHK: begin
        // Pop both stack tops while both stacks hold columns.
        if (ns_r != '0 && nl_r != '0) begin
          ns_nxt    = ns_dec;
          nl_nxt    = nl_dec;
          state_nxt = S_PR_RDS;
        end else begin
          i_nxt     = '0;
          state_nxt = S_OUT_RD;
        end
      end
      S_PR_RDS: begin
        sc_ra      = sm_rd;
        aliasv_nxt = sm_rd;
        l_nxt      = lg_rd;
        state_nxt  = S_PR_RDL;
      end
      S_PR_RDL: begin
        sc_ra     = l_r;
        sv_nxt    = sc_rd;
        state_nxt = S_PR_UPD;
      end
      S_PR_UPD: begin
        // Finish the small column and push back the reduced large column.
        kp_we = 1'b1;
        kp_wa = aliasv_r;
        kp_wd = (sv_r < ONE_FX) ? sv_r[KW-1:0] : ONE_FX[KW-1:0];
        al_we = 1'b1;
        al_wa = aliasv_r;
        al_wd = l_r;
        sc_we = 1'b1;
        sc_wa = l_r;
        sc_wd = nv_w[CW-1:0];
        if (nv_w[CW-1:0] < ONE_FX) begin
          sm_we  = 1'b1;
          sm_wd  = l_r;
          ns_nxt = ns_r + NW'(1);
        end else begin
          lg_we  = 1'b1;
          lg_wd  = l_r;
          nl_nxt = nl_r + NW'(1);
        end
        state_nxt = S_PR_CHK;
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_GO;
      end
      S_OUT_GO: begin
        div_req.start = 1'b1;
        div_req.num   = atb_pkg::NUM_W'(w_eff);
        keepv_nxt     = kp_rd;
        aliasv_nxt    = al_rd;
        state_nxt     = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (div_done) begin
          pmf_nxt   = div_quot;
          state_nxt = S_OUT_EMIT;
        end
      end
      S_OUT_EMIT: begin
        // Load the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.entry_index      = atb_pkg::IDX_W'(i_r);
          out_data_nxt.pmf_value        = pmf_wide[atb_pkg::FRAC_W-1:0];
          out_data_nxt.keep_probability = keep_wide[atb_pkg::FRAC_W-1:0];
          out_data_nxt.alias_index      = atb_pkg::IDX_W'(aliasv_r);
          out_data_nxt.total_weight     = total_r;
          out_data_nxt.uniform_fallback = uni_r;
          out_data_nxt.overflow         = drop_r;
          out_data_nxt.last_entry       = (i_inc == cnt_r);
          i_nxt                         = i_inc;
          if (i_inc == cnt_r) begin
            cnt_nxt   = '0;
            sum_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    uni_r      <= uni_nxt;
    prod_r     <= prod_nxt;
    l_r        <= l_nxt;
    sv_r       <= sv_nxt;
    keepv_r    <= keepv_nxt;
    aliasv_r   <= aliasv_nxt;
    pmf_r      <= pmf_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      sum_r       <= '0;
      drop_r      <= 1'b0;
      i_r         <= '0;
      ns_r        <= '0;
      nl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      drop_r      <= drop_nxt;
      i_r         <= i_nxt;
      ns_r        <= ns_nxt;
      nl_r        <= nl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire

[test/testbench.sv]
// Testbench for alias_table_builder: weight sets in, alias table columns out.
// Depends on atb_pkg and the alias_table_builder RTL; predicts each table itself.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int ENTRIES   = 64;
  localparam int FRAC_BITS = 24;
  localparam longint unsigned ONE_FX = 64'd1 << FRAC_BITS;
  localparam int CYCLE_LIMIT = 3000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  atb_pkg::atb_in_t   in_data;
  logic               out_valid;
  logic               out_ready;
  atb_pkg::atb_out_t  out_data;

  // Predictor state for the set being loaded.
  longint unsigned set_weights[ENTRIES];
  int              set_count;
  longint unsigned set_sum;
  bit              set_dropped;

  // Table columns still to come from the block.
  atb_pkg::atb_out_t column_queue[$];

  int error_count;
  int cycle_count;
  bit quiet;
  int hold_left;

  alias_table_builder #(
    .ENTRIES(ENTRIES),
    .FRACTION_BITS(FRAC_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Global timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Fixed-point floor division: floor(num * 2^FRAC_BITS / den).
  function automatic longint unsigned fx_quot(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = num / den;
    r = num % den;
    for (int b = 0; b < FRAC_BITS; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Builds the alias table over the loaded set and queues its columns.
  task automatic build_table();
    longint unsigned   total;
    longint unsigned   scaled[ENTRIES];
    longint unsigned   keep[ENTRIES];
    int                alias_of[ENTRIES];
    int                small_stk[ENTRIES];
    int                large_stk[ENTRIES];
    int                ns;
    int                nl;
    int                s;
    int                l;
    bit                uniform;
    atb_pkg::atb_out_t col;
    ns = 0;
    nl = 0;
    uniform = 1'b0;
    total = set_sum;
    if (total == 0) begin
      uniform = 1'b1;
      for (int i = 0; i < set_count; i++) set_weights[i] = 1;
      total = set_count;
    end
    for (int i = 0; i < set_count; i++) begin
      scaled[i] = fx_quot(set_weights[i] * set_count, total);
      if (scaled[i] < ONE_FX) small_stk[ns++] = i;
      else large_stk[nl++] = i;
    end
    // Vose pairing, both stacks popped from the top.
    while (ns > 0 && nl > 0) begin
      s = small_stk[--ns];
      l = large_stk[--nl];
      keep[s] = (scaled[s] < ONE_FX) ? scaled[s] : ONE_FX;
      alias_of[s] = l;
      scaled[l] = scaled[l] + scaled[s] - ONE_FX;
      if (scaled[l] < ONE_FX) small_stk[ns++] = l;
      else large_stk[nl++] = l;
    end
    // Leftover columns always keep themselves.
    while (nl > 0) begin
      l = large_stk[--nl];
      keep[l] = ONE_FX;
      alias_of[l] = l;
    end
    while (ns > 0) begin
      s = small_stk[--ns];
      keep[s] = ONE_FX;
      alias_of[s] = s;
    end
    for (int i = 0; i < set_count; i++) begin
      col.entry_index      = i[atb_pkg::IDX_W-1:0];
      col.pmf_value        = atb_pkg::FRAC_W'(fx_quot(set_weights[i], total));
      col.keep_probability = keep[i][atb_pkg::FRAC_W-1:0];
      col.alias_index      = alias_of[i][atb_pkg::IDX_W-1:0];
      col.total_weight     = total[atb_pkg::SUM_W-1:0];
      col.uniform_fallback = uniform;
      col.overflow         = set_dropped;
      col.last_entry       = (i + 1 == set_count);
      column_queue.insert(column_queue.size(), col);
    end
    set_count = 0;
    set_sum = 0;
    set_dropped = 1'b0;
  endtask

  // Updates the predictor with one accepted weight item.
  task automatic absorb_weight(atb_pkg::atb_in_t it);
    longint unsigned w;
    w = 0;
    if (!it.not_finite && !it.weight[31]) w = 64'(it.weight[30:0]);
    if (set_count < ENTRIES) begin
      set_weights[set_count] = w;
      set_sum = (set_sum + w) & ((64'd1 << atb_pkg::SUM_W) - 1);
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (it.last_weight) build_table();
  endtask

  // Offers one item, with an occasional gap first, and waits until it is taken.
  task automatic send_weight(logic signed [31:0] w, logic bad, logic last);
    atb_pkg::atb_in_t it;
    it.weight = w;
    it.not_finite = bad;
    it.last_weight = last;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    absorb_weight(it);
  endtask

  // Sends a whole set of random weights of the given size.
  task automatic send_random_set(int n);
    logic signed [31:0] w;
    logic bad;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      w = $urandom;
      bad = 1'b0;
      if (kind < 4) w = $urandom_range(0, 1000);
      else if (kind == 4) w = 0;
      else if (kind == 5) w[31] = 1'b1;
      else if (kind == 6) bad = 1'b1;
      else if (kind == 7) w = $urandom_range(0, 3);
      send_weight(w, bad, i == n - 1);
    end
  endtask

  // Holds the sender until every expected column has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (column_queue.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch in %s: got %0d, expected %0d", field, got, want);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    atb_pkg::atb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (column_queue.size() == 0) begin
        report_mismatch("unexpected column", out_data.entry_index, 0);
      end else begin
        want = column_queue.pop_front();
        if (out_data.entry_index !== want.entry_index)
          report_mismatch("entry_index", out_data.entry_index, want.entry_index);
        if (out_data.pmf_value !== want.pmf_value)
          report_mismatch("pmf_value", out_data.pmf_value, want.pmf_value);
        if (out_data.keep_probability !== want.keep_probability)
          report_mismatch("keep_probability", out_data.keep_probability,
                          want.keep_probability);
        if (out_data.alias_index !== want.alias_index)
          report_mismatch("alias_index", out_data.alias_index, want.alias_index);
        if (out_data.total_weight !== want.total_weight)
          report_mismatch("total_weight", out_data.total_weight, want.total_weight);
        if (out_data.uniform_fallback !== want.uniform_fallback)
          report_mismatch("uniform_fallback", out_data.uniform_fallback,
                          want.uniform_fallback);
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", out_data.overflow, want.overflow);
        if (out_data.last_entry !== want.last_entry)
          report_mismatch("last_entry", out_data.last_entry, want.last_entry);
      end
    end
  end

  // Receiver: random stall bursts plus an optional long hold-off.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 15);
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Single columns and the extreme weight values.
  task automatic test_extremes();
    send_weight(32'sd5, 1'b0, 1'b1);
    send_weight(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_weight(32'sd1, 1'b0, 1'b0);
    send_weight(32'h8000_0000, 1'b0, 1'b0);
    send_weight(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_weight(32'h7FFF_FFFF, 1'b0, 1'b1);
    send_weight(32'sd3, 1'b0, 1'b0);
    send_weight(32'sd1, 1'b0, 1'b0);
    send_weight(32'sd0, 1'b0, 1'b1);
  endtask

  // All weights zero, negative or not finite: uniform fallback.
  task automatic test_uniform_fallback();
    send_weight(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_weight(32'sd0, 1'b0, 1'b0);
    send_weight(-32'sd7, 1'b0, 1'b1);
    send_weight(32'sd0, 1'b1, 1'b1);
  endtask

  // Full store: items past the last entry are dropped and flagged.
  task automatic test_overflow();
    send_random_set(ENTRIES + 3);
    for (int i = 0; i < ENTRIES; i++) send_weight(32'sd0, 1'b0, i == ENTRIES - 1);
  endtask

  // Long receiver hold-off while the sender keeps offering the next set.
  task automatic test_backpressure();
    hold_left = 3000;
    send_random_set(6);
    send_random_set(5);
    send_random_set(3);
    wait_drained();
  endtask

  // Random sets, mostly small, with the occasional full or overflowing one.
  task automatic test_random(int item_budget);
    int n;
    int sent;
    int pick;
    sent = 0;
    while (sent < item_budget) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) n = $urandom_range(1, 10);
      else if (pick < 18) n = $urandom_range(11, ENTRIES);
      else n = $urandom_range(ENTRIES, ENTRIES + 4);
      send_random_set(n);
      sent += n;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    hold_left = 0;
    error_count = 0;
    cycle_count = 0;
    set_count = 0;
    set_sum = 0;
    set_dropped = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_uniform_fallback();
    test_overflow();
    test_backpressure();
    test_random(100);
    quiet = 1'b1;
    test_random(30);
    in_valid <= 1'b0;

    while (column_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
